// ----- hw/rtl/srpc_pkg.sv -----
// Shared types and constants for the stepper ramp profile controller.
`default_nettype none

package srpc_pkg;

    // Item kinds carried on the input tuser field.
    typedef enum logic [2:0] {
        ACT_MOTION_TICK = 3'd0,
        ACT_START       = 3'd1,
        ACT_STOP        = 3'd2,
        ACT_LOAD_ENTRY  = 3'd3,
        ACT_SELECT      = 3'd4,
        ACT_IDLE_TICK   = 3'd5
    } t_action;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MOTOR_ATTR     = 2'd0,
        CFG_EXT_ATTR       = 2'd1,
        CFG_HOLD_TRANSPORT = 2'd2,
        CFG_HOLD_IDLE      = 2'd3
    } t_cfg_reg;

    // Field widths fixed by the interface.
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned FIELD3_W = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned HOLD_W   = 20;
    localparam int unsigned DWELL_W  = 9;
    localparam int unsigned ENTRY_W  = 16;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 20;

    // Input tdata layout, lowest bit first.
    localparam int unsigned IN_TDATA_W    = 24;
    localparam int unsigned IN_PROF_LSB   = 0;
    localparam int unsigned IN_INDEX_LSB  = 3;
    localparam int unsigned IN_DWELL_LSB  = 6;
    localparam int unsigned IN_CLOCK_LSB  = 14;
    localparam int unsigned IN_TRANSP_BIT = 22;

    // Output tdata layout, lowest bit first.
    localparam int unsigned OUT_TDATA_W    = 40;
    localparam int unsigned OUT_WORD_LSB   = 0;
    localparam int unsigned OUT_EXT_LSB    = 16;
    localparam int unsigned OUT_ENTRY_LSB  = 32;
    localparam int unsigned OUT_MOVING_BIT = 35;
    localparam int unsigned OUT_EXCITE_BIT = 36;
    localparam int unsigned OUT_CLUTCH_BIT = 37;

    // Reset values of the hold count registers.
    localparam logic [HOLD_W-1:0] HOLD_TRANSPORT_RST = 20'd360000;
    localparam logic [HOLD_W-1:0] HOLD_IDLE_RST      = 20'd200;

endpackage

`default_nettype wire

// ----- hw/rtl/stepper_ramp_profile_controller_unit.sv -----
// Top level of the stepper ramp profile controller.
//
// The block takes one command per cycle on the input stream and returns exactly one
// result per command. The accepting edge reads the speed table (current entry and the
// next entry of the active profile at once) into the read stage; when the read stage
// advances, the ramp pointer, dwell and hold counters are updated and the output
// register is loaded with the result, which waits there until the output side takes it.
// The table address for each command is formed from the pointer state that the
// command before it leaves, so a new command can be taken in every cycle; the
// throughput is one command per cycle, limited only by the output side's tready.
// Table loads are written when accepted and are seen by every later command.
// The table has no reset; an entry must be loaded before a profile that uses it
// is selected or ticked. Configuration must be written only while no command is in
// flight; the write port has no interlock against commands in the pipeline.
`default_nettype none

module stepper_ramp_profile_controller_unit
    import srpc_pkg::*;
#(
    parameter int unsigned PROFILE_COUNT       = 8,
    parameter int unsigned ENTRIES_PER_PROFILE = 8,
    parameter int unsigned EXCITE_BIT          = 0,
    parameter int unsigned START_BIT           = 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream: tdata = profile, entry_index, entry_dwell, entry_clock,
    // in_transport (lowest bit first); tuser = action.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [ACTION_W-1:0]    s_axis_tuser,
    // Output stream: tdata = timer_word, timer_word_ext, speed_entry, moving,
    // excited, clutch_release (lowest bit first).
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration write port.
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_AW-1:0]      i_cfg_index,
    input  wire logic [CFG_DW-1:0]      i_cfg_data
);

    localparam int unsigned DEPTH = PROFILE_COUNT * ENTRIES_PER_PROFILE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned PW    = (PROFILE_COUNT > 1) ? $clog2(PROFILE_COUNT) : 1;
    localparam int unsigned IW    = $clog2(ENTRIES_PER_PROFILE);
    localparam logic [WORD_W-1:0] EXCITE_MASK = WORD_W'(1) << EXCITE_BIT;
    localparam logic [WORD_W-1:0] START_MASK  = WORD_W'(1) << START_BIT;
    localparam logic [IW-1:0]     LAST_INDEX  = IW'(ENTRIES_PER_PROFILE - 1);

    // Table address of an entry within a profile.
    function automatic logic [AW-1:0] f_addr(input logic [PW-1:0] p, input logic [IW-1:0] x);
        return AW'(p) * AW'(ENTRIES_PER_PROFILE) + AW'(x);
    endfunction

    // Input field split.
    t_action               w_in_action;
    logic [FIELD3_W-1:0]   w_in_profile;
    logic [FIELD3_W-1:0]   w_in_index;
    logic [BYTE_W-1:0]     w_in_dwell;
    logic [BYTE_W-1:0]     w_in_clock;
    logic                  w_in_transport;
    logic                  w_in_prof_ok;
    logic                  w_in_index_ok;

    assign w_in_action    = t_action'(s_axis_tuser);
    assign w_in_profile   = s_axis_tdata[IN_PROF_LSB +: FIELD3_W];
    assign w_in_index     = s_axis_tdata[IN_INDEX_LSB +: FIELD3_W];
    assign w_in_dwell     = s_axis_tdata[IN_DWELL_LSB +: BYTE_W];
    assign w_in_clock     = s_axis_tdata[IN_CLOCK_LSB +: BYTE_W];
    assign w_in_transport = s_axis_tdata[IN_TRANSP_BIT];
    assign w_in_prof_ok   = (int'(w_in_profile) < PROFILE_COUNT);
    assign w_in_index_ok  = (int'(w_in_index) < ENTRIES_PER_PROFILE);

    // Configuration registers.
    logic [WORD_W-1:0] r_motor_attr;
    logic [WORD_W-1:0] r_ext_attr;
    logic [HOLD_W-1:0] r_hold_transport;
    logic [HOLD_W-1:0] r_hold_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_attr     <= '0;
            r_ext_attr       <= '0;
            r_hold_transport <= HOLD_TRANSPORT_RST;
            r_hold_idle      <= HOLD_IDLE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MOTOR_ATTR:     r_motor_attr     <= i_cfg_data[WORD_W-1:0];
                CFG_EXT_ATTR:       r_ext_attr       <= i_cfg_data[WORD_W-1:0];
                CFG_HOLD_TRANSPORT: r_hold_transport <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_IDLE:      r_hold_idle      <= i_cfg_data[HOLD_W-1:0];
                default:            r_hold_idle      <= r_hold_idle;
            endcase
        end
    end

    // Controller state.
    logic [PW-1:0]      r_profile,     n_profile;
    logic [IW-1:0]      r_speed_index, n_speed_index;
    logic [DWELL_W-1:0] r_dwell,       n_dwell;
    logic               r_ramp_up,     n_ramp_up;
    logic               r_motion,      n_motion;
    logic [HOLD_W-1:0]  r_hold,        n_hold;
    logic [WORD_W-1:0]  r_word,        n_word;
    logic               n_clutch;

    // Read stage and output register.
    logic               r_p_valid;
    t_action            r_p_action;
    logic [FIELD3_W-1:0] r_p_profile;
    logic               r_p_transport;
    logic               r_o_valid;
    logic [WORD_W-1:0]  r_o_word;
    logic [WORD_W-1:0]  r_o_ext;
    logic [FIELD3_W-1:0] r_o_entry;
    logic               r_o_moving;
    logic               r_o_excited;
    logic               r_o_clutch;

    logic w_adv;
    logic w_accept;

    assign w_adv         = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Table reads for the accepted command use the pointer state left by the one before.
    logic [PW-1:0]      w_rd_profile;
    logic [IW-1:0]      w_rd_index;
    logic [IW-1:0]      w_rd_next;
    logic               w_tbl_we;
    logic [ENTRY_W-1:0] w_rdata_cur;
    logic [ENTRY_W-1:0] w_rdata_nxt;

    always_comb begin
        if (w_in_action == ACT_SELECT && w_in_prof_ok) begin
            w_rd_profile = PW'(w_in_profile);
            w_rd_index   = '0;
        end else begin
            w_rd_profile = n_profile;
            w_rd_index   = n_speed_index;
        end
        w_rd_next = (w_rd_index == LAST_INDEX) ? w_rd_index : w_rd_index + IW'(1);
    end

    assign w_tbl_we = w_accept && (w_in_action == ACT_LOAD_ENTRY)
                      && w_in_prof_ok && w_in_index_ok;

    srpc_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_tbl_we),
        .i_waddr   (f_addr(PW'(w_in_profile), IW'(w_in_index))),
        .i_wdata   ({w_in_dwell, w_in_clock}),
        .i_re      (w_accept),
        .i_raddr_a (f_addr(w_rd_profile, w_rd_index)),
        .i_raddr_b (f_addr(w_rd_profile, w_rd_next)),
        .o_rdata_a (w_rdata_cur),
        .o_rdata_b (w_rdata_nxt)
    );

    // Command execution on the table data.
    logic [DWELL_W-1:0] w_cur_dwell;
    logic [DWELL_W-1:0] w_nxt_dwell;
    logic [DWELL_W-1:0] w_dwell_dn;
    logic [DWELL_W-1:0] w_dwell_up;
    logic [HOLD_W-1:0]  w_hold_dn;

    assign w_cur_dwell = DWELL_W'(w_rdata_cur[ENTRY_W-1:BYTE_W]);
    assign w_nxt_dwell = DWELL_W'(w_rdata_nxt[ENTRY_W-1:BYTE_W]);
    assign w_dwell_dn  = r_dwell - DWELL_W'(1);
    assign w_dwell_up  = r_dwell + DWELL_W'(1);
    assign w_hold_dn   = (r_hold != '0) ? r_hold - HOLD_W'(1) : r_hold;

    always_comb begin
        n_profile     = r_profile;
        n_speed_index = r_speed_index;
        n_dwell       = r_dwell;
        n_ramp_up     = r_ramp_up;
        n_motion      = r_motion;
        n_hold        = r_hold;
        n_word        = r_word;
        n_clutch      = 1'b0;
        if (w_adv) begin
            unique case (r_p_action)
                ACT_MOTION_TICK: begin
                    n_word = r_motor_attr | WORD_W'(w_rdata_cur[BYTE_W-1:0]) | START_MASK;
                    n_hold = r_p_transport ? r_hold_transport : r_hold_idle;
                    if (r_ramp_up) begin
                        // Count down; at zero advance and reload from the new entry.
                        if (r_dwell != '0) begin
                            n_dwell = w_dwell_dn;
                            if (w_dwell_dn == '0) begin
                                if (r_speed_index != LAST_INDEX) begin
                                    n_speed_index = r_speed_index + IW'(1);
                                end
                                n_dwell = w_nxt_dwell;
                            end
                        end
                    end else begin
                        // Count up; past the entry's dwell step back toward entry zero.
                        n_dwell = w_dwell_up;
                        if (w_dwell_up > w_cur_dwell) begin
                            n_dwell = DWELL_W'(1);
                            if (r_speed_index != '0) begin
                                n_speed_index = r_speed_index - IW'(1);
                            end
                        end
                    end
                end
                ACT_START: begin
                    n_ramp_up = 1'b1;
                    n_motion  = 1'b1;
                end
                ACT_STOP: begin
                    n_ramp_up = 1'b0;
                    n_motion  = 1'b0;
                    n_word    = r_word & ~(EXCITE_MASK | START_MASK);
                    n_clutch  = 1'b1;
                end
                ACT_SELECT: begin
                    if (int'(r_p_profile) < PROFILE_COUNT) begin
                        n_profile     = PW'(r_p_profile);
                        n_speed_index = '0;
                        n_dwell       = w_cur_dwell;
                        n_word        = r_motor_attr | WORD_W'(w_rdata_cur[BYTE_W-1:0]);
                    end
                end
                ACT_IDLE_TICK: begin
                    // Hold count runs down only while excited; release at zero.
                    if (r_word[EXCITE_BIT]) begin
                        n_hold = w_hold_dn;
                        if (w_hold_dn == '0) begin
                            n_word   = r_word & ~(EXCITE_MASK | START_MASK);
                            n_clutch = 1'b1;
                        end
                    end
                end
                default: begin
                    // Table loads were written at acceptance; unused codes do nothing.
                    n_clutch = 1'b0;
                end
            endcase
        end
    end

    // State update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile     <= '0;
            r_speed_index <= '0;
            r_dwell       <= '0;
            r_ramp_up     <= 1'b0;
            r_motion      <= 1'b0;
            r_hold        <= '0;
            r_word        <= '0;
        end else begin
            r_profile     <= n_profile;
            r_speed_index <= n_speed_index;
            r_dwell       <= n_dwell;
            r_ramp_up     <= n_ramp_up;
            r_motion      <= n_motion;
            r_hold        <= n_hold;
            r_word        <= n_word;
        end
    end

    // Read stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_accept) begin
            r_p_valid <= 1'b1;
        end else if (w_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    // Read stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_action    <= w_in_action;
            r_p_profile   <= w_in_profile;
            r_p_transport <= w_in_transport;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_word    <= n_word;
            r_o_ext     <= r_ext_attr;
            r_o_entry   <= FIELD3_W'(n_speed_index);
            r_o_moving  <= n_motion;
            r_o_excited <= n_word[EXCITE_BIT];
            r_o_clutch  <= n_clutch;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_clutch, r_o_excited, r_o_moving,
                            r_o_entry, r_o_ext, r_o_word};

    // A result that releases the clutch never leaves the motor excited or started.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_clutch |-> !r_o_word[EXCITE_BIT] && !r_o_word[START_BIT])
        else $error("clutch release with excite or start bit set");

    // The excited flag always follows the excite bit of the driven word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_excited == r_o_word[EXCITE_BIT])
        else $error("excited flag differs from timer word");

    // The ramp pointer stays inside the profile.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_speed_index) < ENTRIES_PER_PROFILE)
        else $error("speed index beyond last entry");

    // A command stalled in the read stage is kept, not dropped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid && !w_adv |=> r_p_valid && $stable(r_p_action))
        else $error("stalled command lost");

    // Pointer state moves only when a command completes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_speed_index) && $stable(r_dwell) && $stable(r_hold))
        else $error("state changed without a command");

endmodule

`default_nettype wire

// ----- hw/rtl/srpc_table.sv -----
// Speed entry table: one write port and two registered read ports.
`default_nettype none

module srpc_table
    import srpc_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr_a,
    input  wire logic [AW-1:0]      i_raddr_b,
    output logic      [ENTRY_W-1:0] o_rdata_a,
    output logic      [ENTRY_W-1:0] o_rdata_b
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both read ports are registered and update only when the read enable is set.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the stepper ramp profile controller.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srpc_pkg::*;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 4;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_CMDS     = 180;
    localparam int unsigned PRINT_LIMIT    = 40;

    // Command codes the block ignores.
    localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

    // Timer word bit positions of this build.
    localparam logic [WORD_W-1:0] EXCITE_MASK = 16'h0001;
    localparam logic [WORD_W-1:0] START_MASK  = 16'h0002;
    localparam logic [2:0]        LAST_ENTRY  = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [2:0]          profile;
        logic [2:0]          index;
        logic [7:0]          dwell;
        logic [7:0]          clk_code;
        logic                transport;
    } t_ramp_cmd;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] word_ext;
        logic [2:0]        entry;
        logic              moving;
        logic              excited;
        logic              clutch;
        logic [1:0]        pad;
    } t_timer_result;

    // Clock, reset and block ports.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [ACTION_W-1:0]    s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_index   = '0;
    logic [CFG_DW-1:0]      i_cfg_data    = '0;

    // Shadow copy of the configuration registers.
    logic [WORD_W-1:0] cfg_attr           = '0;
    logic [WORD_W-1:0] cfg_ext_attr       = '0;
    logic [HOLD_W-1:0] cfg_hold_transport = HOLD_TRANSPORT_RST;
    logic [HOLD_W-1:0] cfg_hold_idle      = HOLD_IDLE_RST;

    // Predicted controller state.
    logic [ENTRY_W-1:0] ramp_table [64];
    logic [2:0]         sel_profile  = '0;
    logic [2:0]         entry_ptr    = '0;
    logic [DWELL_W-1:0] dwell_cnt    = '0;
    logic               accel        = 1'b0;
    logic               motion_on    = 1'b0;
    logic               excite_on    = 1'b0;
    logic [HOLD_W-1:0]  hold_cnt     = '0;
    logic [WORD_W-1:0]  drive_word_q = '0;

    t_timer_result expected_timer_results [$];
    t_timer_result got_result;
    t_timer_result want_result;
    t_ramp_cmd     taken_cmd;

    int unsigned cmds_sent       = 0;
    int unsigned cmds_accepted   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned stall_cycles    = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;

    stepper_ramp_profile_controller_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Drives the timer word and keeps the excite flag in step with it.
    function automatic void load_drive_word(input logic [WORD_W-1:0] w);
        drive_word_q = w;
        excite_on    = |(w & EXCITE_MASK);
    endfunction

    // Works out the result of one command and advances the predicted state.
    function automatic t_timer_result predict_timer_result(input t_ramp_cmd c);
        t_timer_result r;
        logic [ENTRY_W-1:0] cur;
        logic clutch;
        clutch = 1'b0;
        case (c.act)
            ACT_MOTION_TICK: begin
                cur = ramp_table[{sel_profile, entry_ptr}];
                load_drive_word(cfg_attr | {8'h00, cur[7:0]} | START_MASK);
                hold_cnt = c.transport ? cfg_hold_transport : cfg_hold_idle;
                if (accel) begin
                    // Acceleration: a zero dwell holds the speed.
                    if (dwell_cnt != 0) begin
                        dwell_cnt = dwell_cnt - DWELL_W'(1);
                        if (dwell_cnt == 0) begin
                            if (entry_ptr != LAST_ENTRY) entry_ptr = entry_ptr + 3'd1;
                            cur = ramp_table[{sel_profile, entry_ptr}];
                            dwell_cnt = {1'b0, cur[15:8]};
                        end
                    end
                end else begin
                    // Deceleration counts up past the dwell and steps back.
                    dwell_cnt = dwell_cnt + DWELL_W'(1);
                    if (dwell_cnt > {1'b0, cur[15:8]}) begin
                        dwell_cnt = 9'd1;
                        if (entry_ptr != 0) entry_ptr = entry_ptr - 3'd1;
                    end
                end
            end
            ACT_START: begin
                accel     = 1'b1;
                motion_on = 1'b1;
            end
            ACT_STOP: begin
                accel     = 1'b0;
                motion_on = 1'b0;
                load_drive_word(drive_word_q & ~(EXCITE_MASK | START_MASK));
                clutch = 1'b1;
            end
            ACT_LOAD_ENTRY: begin
                ramp_table[{c.profile, c.index}] = {c.dwell, c.clk_code};
            end
            ACT_SELECT: begin
                sel_profile = c.profile;
                entry_ptr   = '0;
                cur         = ramp_table[{sel_profile, entry_ptr}];
                dwell_cnt   = {1'b0, cur[15:8]};
                load_drive_word(cfg_attr | {8'h00, cur[7:0]});
            end
            ACT_IDLE_TICK: begin
                // The hold count only runs down while the motor is excited.
                if (excite_on) begin
                    if (hold_cnt != 0) hold_cnt = hold_cnt - HOLD_W'(1);
                    if (hold_cnt == 0) begin
                        load_drive_word(drive_word_q & ~(EXCITE_MASK | START_MASK));
                        clutch = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.word     = drive_word_q;
        r.word_ext = cfg_ext_attr;
        r.entry    = entry_ptr;
        r.moving   = motion_on;
        r.excited  = excite_on;
        r.clutch   = clutch;
        r.pad      = '0;
        return r;
    endfunction

    // Prints one mismatch line (up to a limit) and counts it.
    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on result %0d, %s: expected %h, got %h",
                     $realtime, results_checked, what, want, got);
    endtask

    // Result checker and command tracker, both on pre-edge values.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            got_result.word     = m_axis_tdata[OUT_WORD_LSB +: WORD_W];
            got_result.word_ext = m_axis_tdata[OUT_EXT_LSB +: WORD_W];
            got_result.entry    = m_axis_tdata[OUT_ENTRY_LSB +: 3];
            got_result.moving   = m_axis_tdata[OUT_MOVING_BIT];
            got_result.excited  = m_axis_tdata[OUT_EXCITE_BIT];
            got_result.clutch   = m_axis_tdata[OUT_CLUTCH_BIT];
            got_result.pad      = m_axis_tdata[OUT_TDATA_W-1 -: 2];
            if (expected_timer_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, m_axis_tdata);
            end else begin
                want_result = expected_timer_results.pop_front();
                if (got_result.word !== want_result.word)
                    report_mismatch("timer_word", 40'(want_result.word),
                                    40'(got_result.word));
                if (got_result.word_ext !== want_result.word_ext)
                    report_mismatch("timer_word_ext", 40'(want_result.word_ext),
                                    40'(got_result.word_ext));
                if (got_result.entry !== want_result.entry)
                    report_mismatch("speed_entry", 40'(want_result.entry),
                                    40'(got_result.entry));
                if (got_result.moving !== want_result.moving)
                    report_mismatch("moving", 40'(want_result.moving),
                                    40'(got_result.moving));
                if (got_result.excited !== want_result.excited)
                    report_mismatch("excited", 40'(want_result.excited),
                                    40'(got_result.excited));
                if (got_result.clutch !== want_result.clutch)
                    report_mismatch("clutch_release", 40'(want_result.clutch),
                                    40'(got_result.clutch));
                if (got_result.pad !== want_result.pad)
                    report_mismatch("tdata padding", 40'(want_result.pad),
                                    40'(got_result.pad));
            end
            results_checked++;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            taken_cmd.act       = s_axis_tuser;
            taken_cmd.profile   = s_axis_tdata[IN_PROF_LSB +: FIELD3_W];
            taken_cmd.index     = s_axis_tdata[IN_INDEX_LSB +: FIELD3_W];
            taken_cmd.dwell     = s_axis_tdata[IN_DWELL_LSB +: BYTE_W];
            taken_cmd.clk_code  = s_axis_tdata[IN_CLOCK_LSB +: BYTE_W];
            taken_cmd.transport = s_axis_tdata[IN_TRANSP_BIT];
            expected_timer_results.push_back(predict_timer_result(taken_cmd));
            cmds_accepted <= cmds_accepted + 1;
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output side back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sends one command and returns at the falling edge after its transfer.
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [2:0] prof,
                            input logic [2:0] idx, input logic [7:0] dwell,
                            input logic [7:0] clk_code, input logic transport);
        int unsigned target;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        target = cmds_accepted + 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, transport, clk_code, dwell, idx, prof};
        cmds_sent++;
        do @(negedge i_clk); while (cmds_accepted != target);
    endtask

    // Dwell values lean small so that ramps actually move.
    function automatic logic [7:0] pick_dwell();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    endfunction

    task automatic send_action(input logic [ACTION_W-1:0] act);
        send_cmd(act, 3'($urandom_range(7)), 3'($urandom_range(7)), pick_dwell(),
                 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Stops sending and waits for every pending result, then lets the pipe settle.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_timer_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write; the block must be idle.
    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DW-1:0] val);
        case (idx)
            CFG_MOTOR_ATTR:     cfg_attr           = val[WORD_W-1:0];
            CFG_EXT_ATTR:       cfg_ext_attr       = val[WORD_W-1:0];
            CFG_HOLD_TRANSPORT: cfg_hold_transport = val;
            CFG_HOLD_IDLE:      cfg_hold_idle      = val;
            default: begin
            end
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] attr, input logic [WORD_W-1:0] ext,
                              input logic [HOLD_W-1:0] hold_t, input logic [HOLD_W-1:0] hold_i);
        cfg_write(CFG_MOTOR_ATTR, {4'h0, attr});
        cfg_write(CFG_EXT_ATTR, {4'h0, ext});
        cfg_write(CFG_HOLD_TRANSPORT, hold_t);
        cfg_write(CFG_HOLD_IDLE, hold_i);
    endtask

    // Writes every table entry so no later read finds an empty one. Profile 7
    // ramps one entry per tick and profile 6 starts on a zero dwell.
    task automatic test_table_fill();
        logic [7:0] dwell;
        for (int p = 0; p < 8; p++) begin
            for (int e = 0; e < 8; e++) begin
                if (p == 7)                dwell = 8'd1;
                else if (p == 6 && e == 0) dwell = 8'd0;
                else                       dwell = pick_dwell();
                send_cmd(ACT_LOAD_ENTRY, 3'(p), 3'(e), dwell, 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            end
        end
    endtask

    // Directed corner cases with a short idle hold count and the largest transport hold count.
    task automatic test_directed_ramps();
        wait_for_results();
        set_config(16'hA5A5, 16'hFFFF, 20'hFFFFF, 20'd1);
        // Idle tick while not excited does nothing.
        send_cmd(ACT_IDLE_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        // Select excites the motor with the hold count still zero, so the
        // next idle tick releases at once.
        send_cmd(ACT_SELECT, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        send_cmd(ACT_IDLE_TICK, 3'd7, 3'd7, 8'hFF, 8'hFF, 1'b1);
        // Unused command codes are ignored.
        send_cmd(ACT_SPARE6, 3'd7, 3'd7, 8'hFF, 8'hFF, 1'b1);
        send_cmd(ACT_SPARE7, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        // Extreme table contents.
        send_cmd(ACT_LOAD_ENTRY, 3'd5, 3'd3, 8'hFF, 8'hFF, 1'b1);
        send_cmd(ACT_LOAD_ENTRY, 3'd6, 3'd0, 8'h00, 8'h00, 1'b0);
        // Full acceleration on profile 7 until it saturates at the last entry.
        send_cmd(ACT_SELECT, 3'd7, 3'd0, 8'h00, 8'h00, 1'b0);
        send_cmd(ACT_START, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        for (int t = 0; t < 9; t++)
            send_cmd(ACT_MOTION_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 1'(t & 1));
        // Stop, then ramp back down.
        send_cmd(ACT_STOP, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        repeat (3) send_cmd(ACT_MOTION_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 1'b1);
        // Zero dwell holds the speed; an idle tick then releases with hold 1.
        send_cmd(ACT_SELECT, 3'd6, 3'd0, 8'h00, 8'h00, 1'b0);
        send_cmd(ACT_START, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        repeat (2) send_cmd(ACT_MOTION_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
        send_cmd(ACT_IDLE_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 1'b0);
    endtask

    // A ramp run: optional table loads, select, start, accelerate, stop, decelerate, idle out.
    task automatic run_ramp_episode();
        int unsigned n;
        n = $urandom_range(2);
        repeat (n) send_action(ACT_LOAD_ENTRY);
        send_action(ACT_SELECT);
        send_action(ACT_START);
        n = $urandom_range(1, 14);
        repeat (n) send_action(ACT_MOTION_TICK);
        // Occasionally a stray command lands mid-ramp.
        if ($urandom_range(4) == 0) send_action(3'($urandom_range(7)));
        send_action(ACT_STOP);
        n = $urandom_range(4);
        repeat (n) send_action(ACT_MOTION_TICK);
        n = $urandom_range(10);
        repeat (n) send_action(ACT_IDLE_TICK);
    endtask

    task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [WORD_W-1:0] attr,
                                     input logic [WORD_W-1:0] ext,
                                     input logic [HOLD_W-1:0] hold_t,
                                     input logic [HOLD_W-1:0] hold_i,
                                     input bit with_pause);
        int unsigned first;
        bit paused;
        wait_for_results();
        set_config(attr, ext, hold_t, hold_i);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first  = cmds_sent;
        paused = 1'b0;
        while (cmds_sent - first < PHASE_CMDS) begin
            // Let the output side drain completely once in the middle.
            if (with_pause && !paused && (cmds_sent - first >= PHASE_CMDS / 2)) begin
                wait_for_results();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 8) run_ramp_episode();
            else send_action(3'($urandom_range(7)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_fill();
        test_directed_ramps();
        test_random_phase(0, 0, 16'($urandom_range(65535)) | EXCITE_MASK,
                          16'($urandom_range(65535)), 20'd3, 20'd1, 1'b0);
        test_random_phase(69, 0, 16'hFFFF, 16'h0000, 20'hFFFFF, 20'd5, 1'b1);
        test_random_phase(0, 69, 16'h0000, 16'hFFFF, 20'd1, 20'hFFFFF, 1'b0);
        test_random_phase(15, 15, 16'($urandom_range(65535)) | EXCITE_MASK,
                          16'($urandom_range(65535)), 20'($urandom_range(1, 16)),
                          20'($urandom_range(1, 16)), 1'b0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_for_results();
        if (expected_timer_results.size() != 0)
            report_mismatch("results never produced", 40'(expected_timer_results.size()),
                            '0);

        $display("Covered table fill, directed ramp corners and four handshake phases.");
        $display("%0d commands sent, %0d results compared, %0d mismatches.",
                 cmds_sent, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/srpc_pkg.sv
hw/rtl/srpc_table.sv
hw/rtl/stepper_ramp_profile_controller_unit.sv
dv/tb.sv
